### sv/smp_pkg.sv
// Package holding the phase and event codes of the SEI message parser.
package smp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TYPE  = 3'd1,
        PH_SIZE  = 3'd2,
        PH_RECOV = 3'd3,
        PH_USER  = 3'd4,
        PH_SKIP  = 3'd5,
        PH_BOUND = 3'd6,
        PH_DONE  = 3'd7
    } phase_t;

    localparam logic [2:0] EV_RECOV = 3'd0;
    localparam logic [2:0] EV_UUID  = 3'd1;
    localparam logic [2:0] EV_DATA  = 3'd2;
    localparam logic [2:0] EV_SKIP  = 3'd3;
    localparam logic [2:0] EV_OVER  = 3'd4;
    localparam logic [2:0] EV_TRUNC = 3'd5;
    localparam logic [2:0] EV_END   = 3'd6;
    localparam logic [2:0] EV_BAD   = 3'd7;

    localparam logic CFG_RECOV = 1'b0;
    localparam logic CFG_USER  = 1'b1;

    // Golomb decoder state carried from byte to byte.
    typedef struct packed {
        logic [4:0]  zeros;
        logic [31:0] value;
        logic [4:0]  bits_left;
        logic [1:0]  step;
        logic        exact;
    } gol_t;

    // Outcome of one recovery point byte.
    typedef struct packed {
        logic        fire;     // a result is due for this byte
        logic        bad;      // that result is the malformed event
        logic [30:0] poc;
        logic        exact;
        logic        broken;
    } gol_res_t;

endpackage

### sv/smp_golomb.sv
// Bit-by-bit Exp-Golomb and flag decoder for one recovery point byte.
module smp_golomb
    import smp_pkg::*;
#(
    parameter int MAX_GOLOMB_PREFIX = 30
)
(
    input  logic [7:0] byte_in,
    input  gol_t       gol_cur,
    output gol_t       gol_nxt,
    output gol_res_t   res
);

    always_comb
    begin
        gol_t        g;
        logic        stop;
        logic        bit_v;
        logic [31:0] code;
        g = gol_cur;
        stop = 1'b0;
        res = '0;
        code = '0;
        for (int b = 7; b >= 0; b--)
        begin
            bit_v = byte_in[b];
            if (!stop)
            begin
                case (g.step)
                    2'd0:
                    begin
                        if (!bit_v)
                        begin
                            g.zeros = g.zeros + 5'd1;
                            if (g.zeros > 5'(MAX_GOLOMB_PREFIX))
                            begin
                                res.fire = 1'b1;
                                res.bad  = 1'b1;
                                stop     = 1'b1;
                            end
                        end
                        else
                        begin
                            g.value = '0;
                            if (g.zeros == 5'd0)
                            begin
                                g.step = 2'd2;
                            end
                            else
                            begin
                                g.bits_left = g.zeros;
                                g.step = 2'd1;
                            end
                        end
                    end
                    2'd1:
                    begin
                        g.value = {g.value[30:0], bit_v};
                        g.bits_left = g.bits_left - 5'd1;
                        if (g.bits_left == 5'd0)
                        begin
                            g.step = 2'd2;
                        end
                    end
                    2'd2:
                    begin
                        g.exact = bit_v;
                        g.step = 2'd3;
                    end
                    default:
                    begin
                        code = ((32'd1 << g.zeros) - 32'd1) + g.value;
                        if (g.zeros == 5'd0)
                        begin
                            code = '0;
                        end
                        if (code[0])
                        begin
                            res.poc = 31'((code >> 1) + 32'd1);
                        end
                        else
                        begin
                            res.poc = 31'(32'd0 - (code >> 1));
                        end
                        res.fire   = 1'b1;
                        res.exact  = g.exact;
                        res.broken = bit_v;
                        stop       = 1'b1;
                    end
                endcase
            end
        end
        gol_nxt = g;
    end

endmodule

### sv/sei_message_parser.sv
// Top level of the SEI message parser: header, payload and result queue.
// A byte's first result is registered and on the output in the cycle after the byte is accepted.
// Throughput: one byte a cycle while m_axis_tready is high; a byte with two results holds
// tready low until its first result is taken, set by the two-entry result stage.
// Reset: rst_n clears the parser to idle and the type registers to 6 and 5.
// No memories, so there is no clearing pass after reset.
module sei_message_parser
    import smp_pkg::*;
#(
    parameter int MAX_RBSP_BYTES    = 65535,
    parameter int MAX_GOLOMB_PREFIX = 30
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // byte_in[7:0], bytes_left[23:8], zero fill
    input  logic         s_axis_tuser,  // start_of_unit
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // event_res[2:0], msg_type[18:3], msg_size[34:19], byte_index[50:35],
    // data_byte[58:51], poc_count[89:59], exact_match[90], broken[91], zero fill
    output logic [95:0]  m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam logic [15:0] MAX_LEFT = 16'(MAX_RBSP_BYTES);

    typedef struct packed {
        logic [2:0]  ev;
        logic [15:0] ptype;
        logic [15:0] psize;
        logic [15:0] idx;
        logic [7:0]  db;
        logic [30:0] poc;
        logic        ex;
        logic        br;
    } res_t;

    logic [15:0] recov_type_reg, user_type_reg;
    phase_t      phase_reg, phase_next;
    logic [15:0] type_reg, type_next, size_reg, size_next, count_reg, count_next;
    gol_t        gol_reg, gol_next, gol_in, gol_out;
    gol_res_t    gres;

    // Two-slot result stage: slot 0 is shown, slot 1 holds a second result.
    res_t        r0_reg, r1_reg;
    logic        v0_reg, v1_reg, l0_reg, l1_reg;

    res_t        ra, rb;
    logic        na, nb;

    logic        accept;
    logic [7:0]  byte_in;
    logic        sou;

    assign byte_in = s_axis_tdata[7:0];
    assign sou     = s_axis_tuser;
    assign accept  = s_axis_tvalid && s_axis_tready;

    // Room for a new request when the stage will be empty after this cycle's hand-over.
    assign s_axis_tready = !v1_reg && (!v0_reg || m_axis_tready);

    assign m_axis_tvalid = v0_reg;
    assign m_axis_tlast  = l0_reg;
    assign m_axis_tdata  = {4'd0, r0_reg.br, r0_reg.ex, r0_reg.poc, r0_reg.db,
                            r0_reg.idx, r0_reg.psize, r0_reg.ptype, r0_reg.ev};

    smp_golomb #(.MAX_GOLOMB_PREFIX(MAX_GOLOMB_PREFIX)) u_golomb
    (
        .byte_in (byte_in),
        .gol_cur (gol_in),
        .gol_nxt (gol_out),
        .res     (gres)
    );

    always_comb
    begin
        logic [15:0] l;
        logic        lastb;
        logic [15:0] after;
        logic [16:0] s;
        logic [15:0] tsum, ssum, cnt;
        logic        hold;
        phase_t      ph;
        l = s_axis_tdata[23:8];
        if (l > MAX_LEFT)
        begin
            l = MAX_LEFT;
        end
        if (l == 16'd0)
        begin
            l = 16'd1;
        end
        lastb = (l <= 16'd1);
        after = l - 16'd1;
        na = 1'b0;
        nb = 1'b0;
        ra = '0;
        rb = '0;
        hold = 1'b0;
        ph   = phase_reg;
        tsum = type_reg;
        ssum = size_reg;
        cnt  = count_reg;
        gol_in = gol_reg;
        s = '0;

        if (sou)
        begin
            tsum = '0; ssum = '0; cnt = '0; gol_in = '0; ph = PH_TYPE;
        end
        else if (ph == PH_IDLE || ph == PH_DONE)
        begin
            hold = 1'b1;
        end
        else if (ph == PH_BOUND)
        begin
            if (byte_in == 8'h80 && lastb)
            begin
                na = 1'b1;
                ra.ev = EV_END;
                ph = PH_DONE;
                hold = 1'b1;
            end
            else
            begin
                tsum = '0; ssum = '0; cnt = '0; gol_in = '0; ph = PH_TYPE;
            end
        end

        if (!hold)
        begin
            case (ph)
                PH_TYPE:
                begin
                    s = {1'b0, tsum} + {9'd0, byte_in};
                    tsum = s[16] ? 16'hFFFF : s[15:0];
                    if (byte_in != 8'hFF || lastb)
                    begin
                        ph = PH_SIZE;
                    end
                end
                PH_SIZE:
                begin
                    s = {1'b0, ssum} + {9'd0, byte_in};
                    ssum = s[16] ? 16'hFFFF : s[15:0];
                    if (!(byte_in == 8'hFF && !lastb))
                    begin
                        if (ssum > after)
                        begin
                            na = 1'b1; ra.ev = EV_OVER; ph = PH_DONE;
                        end
                        else
                        begin
                            cnt = '0;
                            gol_in = '0;
                            if (tsum == recov_type_reg)
                            begin
                                ph = PH_RECOV;
                            end
                            else if (tsum == user_type_reg)
                            begin
                                ph = PH_USER;
                            end
                            else
                            begin
                                na = 1'b1; ra.ev = EV_SKIP; ph = PH_SKIP;
                            end
                            if (ssum == 16'd0)
                            begin
                                if (ph == PH_RECOV)
                                begin
                                    na = 1'b1; ra.ev = EV_BAD;
                                end
                                if (lastb)
                                begin
                                    if (na)
                                    begin
                                        nb = 1'b1; rb.ev = EV_END;
                                    end
                                    else
                                    begin
                                        na = 1'b1; ra.ev = EV_END;
                                    end
                                    ph = PH_DONE;
                                end
                                else
                                begin
                                    ph = PH_BOUND;
                                end
                            end
                        end
                    end
                end
                PH_RECOV, PH_USER, PH_SKIP:
                begin
                    if (ph == PH_RECOV)
                    begin
                        gol_in = gol_reg;
                        if (gres.fire)
                        begin
                            na = 1'b1;
                            ra.ev = gres.bad ? EV_BAD : EV_RECOV;
                            ra.poc = gres.poc;
                            ra.ex = gres.exact;
                            ra.br = gres.broken;
                            ph = PH_SKIP;
                        end
                    end
                    else if (ph == PH_USER)
                    begin
                        na = 1'b1;
                        ra.ev = (cnt < 16'd16) ? EV_UUID : EV_DATA;
                        ra.idx = cnt;
                        ra.db = byte_in;
                    end
                    cnt = cnt + 16'd1;
                    if (cnt >= ssum)
                    begin
                        if (ph == PH_RECOV)
                        begin
                            if (na) begin nb = 1'b1; rb.ev = EV_BAD; end
                            else begin na = 1'b1; ra.ev = EV_BAD; end
                        end
                        if (lastb)
                        begin
                            if (na) begin nb = 1'b1; rb.ev = EV_END; end
                            else begin na = 1'b1; ra.ev = EV_END; end
                            ph = PH_DONE;
                        end
                        else
                        begin
                            ph = PH_BOUND;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (lastb && ph != PH_DONE && ph != PH_IDLE)
            begin
                if (na) begin nb = 1'b1; rb.ev = EV_TRUNC; end
                else begin na = 1'b1; ra.ev = EV_TRUNC; end
                ph = PH_DONE;
            end
        end

        // Every result carries the accumulators as they stand after this byte.
        ra.ptype = tsum; ra.psize = ssum;
        rb.ptype = tsum; rb.psize = ssum;

        phase_next = ph;
        type_next  = tsum;
        size_next  = ssum;
        count_next = cnt;
        gol_next   = (phase_reg == PH_RECOV && !sou && ph != PH_BOUND) ? gol_out : gol_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recov_type_reg <= 16'd6;
            user_type_reg  <= 16'd5;
            phase_reg      <= PH_IDLE;
            type_reg       <= '0;
            size_reg       <= '0;
            count_reg      <= '0;
            gol_reg        <= '0;
            v0_reg         <= 1'b0;
            v1_reg         <= 1'b0;
            l0_reg         <= 1'b0;
            l1_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RECOV: recov_type_reg <= cfg_data;
                    CFG_USER:  user_type_reg  <= cfg_data;
                    default:   recov_type_reg <= recov_type_reg;
                endcase
            end
            if (v0_reg && m_axis_tready)
            begin
                v0_reg <= v1_reg;
                l0_reg <= l1_reg;
                r0_reg <= r1_reg;
                v1_reg <= 1'b0;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                type_reg  <= type_next;
                size_reg  <= size_next;
                count_reg <= count_next;
                gol_reg   <= gol_next;
                if (na)
                begin
                    v0_reg <= 1'b1;
                    r0_reg <= ra;
                    l0_reg <= !nb;
                    v1_reg <= nb;
                    r1_reg <= rb;
                    l1_reg <= 1'b1;
                end
            end
        end
    end

endmodule
